FILE: design/saws_pkg.sv
// shared types and constants for the stop-and-wait sender
package saws_pkg;

   localparam int MAX_MESSAGE = 1024;
   localparam int ADDR_W      = $clog2(MAX_MESSAGE);
   localparam int LEN_W       = $clog2(MAX_MESSAGE + 1);
   localparam int SEG_BYTES   = 6;
   localparam int SEG_CNT_W   = $clog2(SEG_BYTES);
   localparam int BYTE_W      = 8;
   localparam int PAYLOAD_W   = SEG_BYTES * BYTE_W;
   localparam int CK_W        = 11;
   localparam int ACK_CK_W    = 16;
   localparam int KIND_W      = 2;
   localparam int SEQ_W       = 2;
   localparam logic [SEQ_W-1:0] FIN_SEQ = SEQ_W'(2);

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD    = 2'd0,
      KIND_ACK     = 2'd1,
      KIND_TIMEOUT = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_ACCEPT,
      ST_BUILD,
      ST_DRAIN,
      ST_SEND,
      ST_FIN_A,
      ST_FIN_B
   } ctrl_state_type;

   typedef struct packed {
      logic clear;
      logic take;
   } bld_ctl_type;

endpackage

FILE: design/saws_ifs.sv
// request and response channel interfaces
interface saws_req_if;
   logic                           valid;
   logic                           ready;
   logic [saws_pkg::KIND_W-1:0]    kind;
   logic [saws_pkg::BYTE_W-1:0]    message_byte;
   logic                           final_byte;
   logic [saws_pkg::SEQ_W-1:0]     ack_seq;
   logic [saws_pkg::ACK_CK_W-1:0]  ack_checksum;

   modport source (output valid, kind, message_byte, final_byte, ack_seq, ack_checksum,
                   input ready);
   modport sink (input valid, kind, message_byte, final_byte, ack_seq, ack_checksum,
                 output ready);
endinterface

interface saws_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [saws_pkg::SEQ_W-1:0]      packet_seq;
   logic [saws_pkg::PAYLOAD_W-1:0]  payload;
   logic [saws_pkg::CK_W-1:0]       packet_checksum;
   logic                            last_of_run;

   modport source (output valid, packet_seq, payload, packet_checksum, last_of_run,
                   input ready);
   modport sink (input valid, packet_seq, payload, packet_checksum, last_of_run,
                 output ready);
endinterface

FILE: design/saws_msg_ram.sv
// message byte buffer, one write port and one registered read port
module saws_msg_ram (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [saws_pkg::ADDR_W-1:0]   wr_addr,
   input  logic [saws_pkg::BYTE_W-1:0]   wr_data,
   input  logic                          rd_en,
   input  logic [saws_pkg::ADDR_W-1:0]   rd_addr,
   output logic [saws_pkg::BYTE_W-1:0]   rd_data
);
   import saws_pkg::*;

   logic [BYTE_W-1:0] mem [MAX_MESSAGE];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/saws_pkt_builder.sv
// packet assembly: shifts in payload bytes and accumulates the checksum
module saws_pkt_builder (
   input  logic                             clock,
   input  logic                             reset,
   input  saws_pkg::bld_ctl_type            ctl,
   input  logic [saws_pkg::BYTE_W-1:0]      data,
   output logic [saws_pkg::PAYLOAD_W-1:0]   payload,
   output logic [saws_pkg::CK_W-1:0]        checksum
);
   import saws_pkg::*;

   logic [PAYLOAD_W-1:0] pay_ff;
   logic [PAYLOAD_W-1:0] pay_in;
   logic [CK_W-1:0]      sum_ff;
   logic [CK_W-1:0]      sum_in;
   logic                 stop_ff;
   logic                 stop_in;

   always_comb begin
      pay_in  = pay_ff;
      sum_in  = sum_ff;
      stop_in = stop_ff;
      if (ctl.clear) begin
         sum_in  = '0;
         stop_in = 1'b0;
      end else if (ctl.take) begin
         // first byte ends up in the low bits after six shifts
         pay_in = {data, pay_ff[PAYLOAD_W-1:BYTE_W]};
         if (data == '0) begin
            stop_in = 1'b1;
         end else if (!stop_ff) begin
            sum_in = sum_ff + CK_W'(data);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_ff <= 1'b0;
         sum_ff  <= '0;
      end else begin
         stop_ff <= stop_in;
         sum_ff  <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      pay_ff <= pay_in;
   end

   assign payload  = pay_ff;
   assign checksum = sum_ff;

endmodule

FILE: design/stop_and_wait_sender.sv
// stop-and-wait (alternating bit) sender top level
//
//  channel  dir  handshake      carries
//  req_if   in   valid/ready    kind, message_byte, final_byte, ack_seq, ack_checksum
//  rsp_if   out  valid/ready    packet_seq, payload, packet_checksum, last_of_run
//
// a byte load, an ignored transaction and a bad ack are handled in the accepting state alone
// a packet build passes the accepting state, six reads of the message buffer in the
//   build state, a drain state for the registered read, then the send state, which waits on rsp_if.ready
// a timeout resend passes the accepting state, then the send state, which waits on rsp_if.ready
// a good final ack gives two fin packets, one per response handshake
// reset is synchronous; the message buffer itself is not cleared, only the length
// req_if.ready is low while a packet is built or a response waits
module stop_and_wait_sender (
   input  logic        clock,
   input  logic        reset,
   saws_req_if.sink    req_if,
   saws_rsp_if.source  rsp_if
);
   import saws_pkg::*;

   ctrl_state_type       state_ff;
   ctrl_state_type       state_in;
   logic                 sending_ff;
   logic                 sending_in;
   logic [LEN_W-1:0]     len_ff;
   logic [LEN_W-1:0]     len_in;
   logic [LEN_W-1:0]     offset_ff;
   logic [LEN_W-1:0]     offset_in;
   logic                 seq_ff;
   logic                 seq_in;
   logic [SEG_CNT_W-1:0] cnt_ff;
   logic [SEG_CNT_W-1:0] cnt_in;
   logic                 take_ff;
   logic                 inrange_ff;

   logic                 accept;
   logic                 ack_ok;
   logic                 ack_done;
   logic [LEN_W:0]       offset_next;
   logic [LEN_W:0]       rd_idx;
   logic                 in_range;
   logic                 buf_wr_en;
   logic                 buf_rd_en;
   logic [BYTE_W-1:0]    buf_rd_data;
   logic [BYTE_W-1:0]    bld_data;
   bld_ctl_type          bld_ctl;
   logic [PAYLOAD_W-1:0] pkt_payload;
   logic [CK_W-1:0]      pkt_ck;

   assign accept = req_if.valid && req_if.ready;

   // an ack must echo both the current sequence bit and the checksum
   assign ack_ok = (req_if.ack_seq == SEQ_W'(seq_ff)) &&
                   (req_if.ack_checksum == ACK_CK_W'(pkt_ck));

   assign offset_next = {1'b0, offset_ff} + (LEN_W+1)'(SEG_BYTES);
   assign ack_done    = offset_next >= {1'b0, len_ff};

   // byte index of the current read; past the message end it pads with zero
   assign rd_idx   = {1'b0, offset_ff} + (LEN_W+1)'(cnt_ff);
   assign in_range = rd_idx < {1'b0, len_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_ACCEPT: begin
            if (accept) begin
               case (kind_type'(req_if.kind))
                  KIND_LOAD: begin
                     if (!sending_ff && req_if.final_byte) begin
                        state_in = ST_BUILD;
                     end
                  end
                  KIND_ACK: begin
                     if (sending_ff && ack_ok) begin
                        state_in = ack_done ? ST_FIN_A : ST_BUILD;
                     end
                  end
                  KIND_TIMEOUT: begin
                     if (sending_ff) begin
                        state_in = ST_SEND;
                     end
                  end
                  default: state_in = ST_ACCEPT;
               endcase
            end
         end
         ST_BUILD: begin
            if (cnt_ff == SEG_CNT_W'(SEG_BYTES - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_SEND;
         ST_SEND: begin
            if (rsp_if.ready) begin
               state_in = ST_ACCEPT;
            end
         end
         ST_FIN_A: begin
            if (rsp_if.ready) begin
               state_in = ST_FIN_B;
            end
         end
         ST_FIN_B: begin
            if (rsp_if.ready) begin
               state_in = ST_ACCEPT;
            end
         end
         default: state_in = ST_ACCEPT;
      endcase
   end

   // protocol state: length, offset, sequence bit, sending phase
   always_comb begin
      sending_in = sending_ff;
      len_in     = len_ff;
      offset_in  = offset_ff;
      seq_in     = seq_ff;
      if (state_ff == ST_ACCEPT && accept) begin
         case (kind_type'(req_if.kind))
            KIND_LOAD: begin
               if (!sending_ff) begin
                  // bytes past a full buffer are dropped
                  if (len_ff < LEN_W'(MAX_MESSAGE)) begin
                     len_in = len_ff + LEN_W'(1);
                  end
                  if (req_if.final_byte) begin
                     sending_in = 1'b1;
                     offset_in  = '0;
                     seq_in     = 1'b0;
                  end
               end
            end
            KIND_ACK: begin
               if (sending_ff && ack_ok) begin
                  if (ack_done) begin
                     sending_in = 1'b0;
                     len_in     = '0;
                     offset_in  = '0;
                     seq_in     = 1'b0;
                  end else begin
                     offset_in = offset_next[LEN_W-1:0];
                     seq_in    = !seq_ff;
                  end
               end
            end
            default: sending_in = sending_ff;
         endcase
      end
   end

   assign cnt_in = (state_ff == ST_BUILD) ? cnt_ff + SEG_CNT_W'(1) : '0;

   // outputs of the control
   always_comb begin
      req_if.ready       = (state_ff == ST_ACCEPT);
      rsp_if.valid       = 1'b0;
      rsp_if.packet_seq  = SEQ_W'(seq_ff);
      rsp_if.payload     = pkt_payload;
      rsp_if.packet_checksum = pkt_ck;
      rsp_if.last_of_run = 1'b1;
      buf_rd_en          = (state_ff == ST_BUILD);
      bld_ctl.clear      = (state_ff == ST_ACCEPT) && (state_in == ST_BUILD);
      bld_ctl.take       = take_ff;
      case (state_ff)
         ST_SEND: rsp_if.valid = 1'b1;
         ST_FIN_A: begin
            rsp_if.valid           = 1'b1;
            rsp_if.packet_seq      = FIN_SEQ;
            rsp_if.payload         = '0;
            rsp_if.packet_checksum = '0;
            rsp_if.last_of_run     = 1'b0;
         end
         ST_FIN_B: begin
            rsp_if.valid           = 1'b1;
            rsp_if.packet_seq      = FIN_SEQ;
            rsp_if.payload         = '0;
            rsp_if.packet_checksum = '0;
         end
         default: rsp_if.valid = 1'b0;
      endcase
   end

   // loads write only while accepting and builds read only in their own
   // states, so the buffer never sees a write and a read together
   assign buf_wr_en = (state_ff == ST_ACCEPT) && accept &&
                      (req_if.kind == KIND_LOAD) && !sending_ff &&
                      (len_ff < LEN_W'(MAX_MESSAGE));

   assign bld_data = inrange_ff ? buf_rd_data : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_ACCEPT;
         sending_ff <= 1'b0;
         len_ff     <= '0;
         offset_ff  <= '0;
         seq_ff     <= 1'b0;
         cnt_ff     <= '0;
         take_ff    <= 1'b0;
         inrange_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         sending_ff <= sending_in;
         len_ff     <= len_in;
         offset_ff  <= offset_in;
         seq_ff     <= seq_in;
         cnt_ff     <= cnt_in;
         take_ff    <= buf_rd_en;
         inrange_ff <= in_range;
      end
   end

   saws_msg_ram u_msg_ram (
      .clock   (clock),
      .wr_en   (buf_wr_en),
      .wr_addr (len_ff[ADDR_W-1:0]),
      .wr_data (req_if.message_byte),
      .rd_en   (buf_rd_en),
      .rd_addr (rd_idx[ADDR_W-1:0]),
      .rd_data (buf_rd_data)
   );

   saws_pkt_builder u_pkt_builder (
      .clock    (clock),
      .reset    (reset),
      .ctl      (bld_ctl),
      .data     (bld_data),
      .payload  (pkt_payload),
      .checksum (pkt_ck)
   );

   // a response never waits while a new transaction is taken
   a_rsp_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> !req_if.ready)
      else $error("request accepted while a response is pending");

   // the packet start always lies inside the message while sending
   a_offset_in_msg: assert property (@(posedge clock) disable iff (reset)
      sending_ff |-> (offset_ff < len_ff))
      else $error("send offset outside the message");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(MAX_MESSAGE))
      else $error("message length above buffer size");

   // the good final ack clears the message; after the second fin the block is idle and empty
   a_fin_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN_B && rsp_if.ready) |=> (!sending_ff && len_ff == '0))
      else $error("fin packets sent without clearing the message");

endmodule
